// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/bsd_pkg.sv -----
package bsd_pkg;

	typedef enum logic [1:0] {
		LVL_FRAME     = 2'd0,
		LVL_NO_ETH    = 2'd1,
		LVL_IP        = 2'd2,
		LVL_TRANSPORT = 2'd3
	} level_t;

	typedef enum logic [2:0] {
		REG_PAYLOAD_LEVEL = 3'd0,
		REG_GAP_THRESHOLD = 3'd1,
		REG_PS_PER_BYTE   = 3'd2,
		REG_MIN_PACKETS   = 3'd3,
		REG_RELATIVE_MODE = 3'd4
	} reg_index_t;

	localparam logic        OP_FLUSH      = 1'b1;
	localparam logic [17:0] ETH_HDR_BYTES = 18'd14;
	localparam logic [17:0] UDP_HDR_BYTES = 18'd8;
	localparam logic [15:0] ET_IPV4       = 16'h0800;
	localparam logic [15:0] ET_VLAN       = 16'h8100;
	localparam logic [7:0]  PROTO_TCP     = 8'd6;
	localparam logic [7:0]  PROTO_UDP     = 8'd17;
	localparam logic [31:0] PPB_RESET     = 32'd800000;
	localparam logic [7:0]  MINP_RESET    = 8'd2;
	localparam logic [31:0] PKT_MAX       = 32'hFFFF_FFFF;
	localparam logic [47:0] BYTE_MAX      = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		level_t      level;
		logic [47:0] gap;
		logic [31:0] ppb;
		logic [7:0]  min_pkts;
		logic        rel;
	} cfg_t;

	typedef struct packed {
		logic        valid;
		logic        flush;
		logic [15:0] pay;
		logic [63:0] t_abs;
		logic [47:0] pay_time;
	} item_t;

	typedef struct packed {
		logic [63:0] start_ps;
		logic [63:0] stop_ps;
		logic [31:0] packets;
		logic [47:0] bytes;
		logic [63:0] duration_ps;
		logic        flush;
	} rec_t;

endpackage

// ----- hw/rtl/packet_burst_session_detector.sv -----
// Channel | Handshake                 | Carries
// cfg     | cfg_valid / cfg_ready     | cfg_index, cfg_data (register write)
// desc    | desc_valid / desc_stall   | one packet descriptor or flush word
// sess    | sess_valid / sess_stall   | one session record word
//
// One descriptor word per cycle while desc_stall is low; a record word passes through the
// input, multiply, time-add and record registers after its descriptor word.
// arst_n clears session state and loads register reset values.
// A record held by sess_stall freezes all stages and raises desc_stall.
module packet_burst_session_detector (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data,
	input  logic        desc_valid,
	output logic        desc_stall,
	input  logic        operation,
	input  logic [63:0] timestamp_ps,
	input  logic [15:0] captured_length,
	input  logic [15:0] ethertype,
	input  logic [15:0] ip_total_length,
	input  logic [3:0]  ip_header_words,
	input  logic [7:0]  ip_protocol,
	input  logic [3:0]  tcp_offset_words,
	input  logic [15:0] udp_length,
	output logic        sess_valid,
	input  logic        sess_stall,
	output logic [63:0] session_start_ps,
	output logic [63:0] session_end_ps,
	output logic [31:0] session_packets,
	output logic [47:0] session_bytes,
	output logic [63:0] session_duration_ps,
	output logic        from_flush
);
	import bsd_pkg::*;

	cfg_t  cfg_q;
	item_t item;
	rec_t  rec;
	logic  advance;

	assign cfg_ready  = 1'b1;
	assign advance    = !(sess_valid && sess_stall);
	assign desc_stall = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.level    <= LVL_FRAME;
			cfg_q.gap      <= '0;
			cfg_q.ppb      <= PPB_RESET;
			cfg_q.min_pkts <= MINP_RESET;
			cfg_q.rel      <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_index_t'(cfg_index))
				REG_PAYLOAD_LEVEL: cfg_q.level    <= level_t'(cfg_data[1:0]);
				REG_GAP_THRESHOLD: cfg_q.gap      <= cfg_data;
				REG_PS_PER_BYTE:   cfg_q.ppb      <= cfg_data[31:0];
				REG_MIN_PACKETS:   cfg_q.min_pkts <= cfg_data[7:0];
				REG_RELATIVE_MODE: cfg_q.rel      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	bsd_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.advance          (advance),
		.desc_valid       (desc_valid),
		.operation        (operation),
		.timestamp_ps     (timestamp_ps),
		.captured_length  (captured_length),
		.ethertype        (ethertype),
		.ip_total_length  (ip_total_length),
		.ip_header_words  (ip_header_words),
		.ip_protocol      (ip_protocol),
		.tcp_offset_words (tcp_offset_words),
		.udp_length       (udp_length),
		.cfg              (cfg_q),
		.item             (item)
	);

	bsd_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.item      (item),
		.cfg       (cfg_q),
		.rec_valid (sess_valid),
		.rec       (rec)
	);

	assign session_start_ps    = rec.start_ps;
	assign session_end_ps      = rec.stop_ps;
	assign session_packets     = rec.packets;
	assign session_bytes       = rec.bytes;
	assign session_duration_ps = rec.duration_ps;
	assign from_flush          = rec.flush;

endmodule

// ----- hw/rtl/bsd_front.sv -----
module bsd_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  logic           desc_valid,
	input  logic           operation,
	input  logic [63:0]    timestamp_ps,
	input  logic [15:0]    captured_length,
	input  logic [15:0]    ethertype,
	input  logic [15:0]    ip_total_length,
	input  logic [3:0]     ip_header_words,
	input  logic [7:0]     ip_protocol,
	input  logic [3:0]     tcp_offset_words,
	input  logic [15:0]    udp_length,
	input  bsd_pkg::cfg_t  cfg,
	output bsd_pkg::item_t item
);
	import bsd_pkg::*;

	logic        valid_s1, op_s1;
	logic [63:0] ts_s1;
	logic [15:0] len_s1, et_s1, ipl_s1, udpl_s1;
	logic [3:0]  ihw_s1, tcpw_s1;
	logic [7:0]  proto_s1;

	logic               valid_s2, flush_s2;
	logic [15:0]        pay_s2;
	logic [63:0]        ts_s2;
	logic signed [50:0] hdr_s2;
	logic [47:0]        ptime_s2;

	logic        valid_s3, flush_s3;
	logic [15:0] pay_s3;
	logic [63:0] tabs_s3;
	logic [47:0] ptime_s3;

	logic               ip_ok;
	logic signed [17:0] len18, ipl18, udp18, ihl18, doff18, p, hdr_diff;
	logic [15:0]        pay;
	logic signed [50:0] hdr_prod;
	logic [47:0]        pay_prod;

	always_comb begin
		ip_ok  = (et_s1 == ET_IPV4) || (et_s1 == ET_VLAN);
		len18  = {2'b0, len_s1};
		ipl18  = {2'b0, ipl_s1};
		udp18  = {2'b0, udpl_s1};
		ihl18  = {12'b0, ihw_s1, 2'b0};
		doff18 = {12'b0, tcpw_s1, 2'b0};
		p      = '0;
		unique case (cfg.level)
			LVL_FRAME:  p = len18;
			LVL_NO_ETH: p = len18 - ETH_HDR_BYTES;
			LVL_IP: begin
				if (ip_ok)
					p = ipl18 - ihl18;
			end
			LVL_TRANSPORT: begin
				if (ip_ok && proto_s1 == PROTO_TCP)
					p = ipl18 - doff18 - ihl18;
				else if (ip_ok && proto_s1 == PROTO_UDP)
					p = udp18 - UDP_HDR_BYTES;
			end
			default: p = '0;
		endcase
		pay      = p[17] ? 16'd0 : p[15:0];
		hdr_diff = len18 - {2'b0, pay};
		hdr_prod = 51'(hdr_diff) * 51'($signed({1'b0, cfg.ppb}));
		pay_prod = 48'(pay) * 48'(cfg.ppb);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= desc_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (desc_valid) begin
				op_s1    <= operation;
				ts_s1    <= timestamp_ps;
				len_s1   <= captured_length;
				et_s1    <= ethertype;
				ipl_s1   <= ip_total_length;
				ihw_s1   <= ip_header_words;
				proto_s1 <= ip_protocol;
				tcpw_s1  <= tcp_offset_words;
				udpl_s1  <= udp_length;
			end
			flush_s2 <= (op_s1 == OP_FLUSH);
			pay_s2   <= pay;
			ts_s2    <= ts_s1;
			hdr_s2   <= hdr_prod;
			ptime_s2 <= pay_prod;
			flush_s3 <= flush_s2;
			pay_s3   <= pay_s2;
			tabs_s3  <= ts_s2 + {{13{hdr_s2[50]}}, hdr_s2};
			ptime_s3 <= ptime_s2;
		end
	end

	assign item = '{valid: valid_s3, flush: flush_s3, pay: pay_s3,
		t_abs: tabs_s3, pay_time: ptime_s3};

endmodule

// ----- hw/rtl/bsd_track.sv -----
module bsd_track (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  bsd_pkg::item_t item,
	input  bsd_pkg::cfg_t  cfg,
	output logic           rec_valid,
	output bsd_pkg::rec_t  rec
);
	import bsd_pkg::*;

	logic [31:0] count_q;
	logic [47:0] bytes_q;
	logic [63:0] start_q, last_q, ref_q;
	logic        seen_q;
	logic        rec_valid_q;
	rec_t        rec_q;

	logic [63:0] ref_eff, t, d;
	logic [48:0] byte_sum;
	logic [47:0] bytes_sat;
	logic [31:0] count_inc;
	logic        take, pkt, gap, restart, emit_gap, emit;

	always_comb begin
		take      = advance && item.valid;
		pkt       = take && !item.flush && (item.pay != 16'd0);
		ref_eff   = seen_q ? ref_q : item.t_abs;
		t         = cfg.rel ? item.t_abs - ref_eff : item.t_abs;
		d         = t - last_q;
		gap       = !d[63] && (d > {16'b0, cfg.gap});
		restart   = (count_q == 32'd0) || gap;
		emit_gap  = (count_q != 32'd0) && gap && (count_q >= {24'b0, cfg.min_pkts});
		emit      = take && (item.flush || (pkt && emit_gap));
		byte_sum  = {1'b0, bytes_q} + {33'b0, item.pay};
		bytes_sat = byte_sum[48] ? BYTE_MAX : byte_sum[47:0];
		count_inc = (count_q == PKT_MAX) ? count_q : count_q + 32'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			bytes_q <= '0;
			start_q <= '0;
			last_q  <= '0;
			ref_q   <= '0;
			seen_q  <= 1'b0;
		end else if (take && item.flush) begin
			count_q <= '0;
			bytes_q <= '0;
			start_q <= '0;
			last_q  <= '0;
			ref_q   <= '0;
			seen_q  <= 1'b0;
		end else if (pkt) begin
			seen_q <= 1'b1;
			if (!seen_q && cfg.rel)
				ref_q <= item.t_abs;
			if (restart) begin
				start_q <= t;
				count_q <= 32'd1;
				bytes_q <= {32'b0, item.pay};
			end else begin
				count_q <= count_inc;
				bytes_q <= bytes_sat;
			end
			last_q <= t + {16'b0, item.pay_time};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rec_valid_q <= 1'b0;
		else if (advance)
			rec_valid_q <= emit;
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			rec_q.start_ps    <= start_q;
			rec_q.stop_ps     <= last_q;
			rec_q.packets     <= count_q;
			rec_q.bytes       <= bytes_q;
			rec_q.duration_ps <= last_q - start_q;
			rec_q.flush       <= item.flush;
		end
	end

	assign rec_valid = rec_valid_q;
	assign rec       = rec_q;

endmodule

// ----- hw/rtl/bsd_checker.sv -----
`include "assert_macros.svh"

module bsd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        desc_valid,
	input logic        desc_stall,
	input logic        sess_valid,
	input logic        sess_stall,
	input logic [63:0] session_start_ps,
	input logic [63:0] session_end_ps,
	input logic [31:0] session_packets,
	input logic [63:0] session_duration_ps,
	input logic        from_flush
);

	`ASSERT_NEXT(a_rec_hold, clk, arst_n, sess_valid && sess_stall, sess_valid && $stable(session_start_ps), "stalled record word changed")
	`ASSERT_IMPL(a_stall_cause, clk, arst_n, desc_stall, sess_valid && sess_stall, "descriptor stall without a waiting record")
	`ASSERT_IMPL(a_gap_rec_nonempty, clk, arst_n, sess_valid && !from_flush, session_packets != 32'd0, "gap record with no packets")
	`ASSERT_IMPL(a_duration, clk, arst_n, sess_valid && desc_valid, session_duration_ps == session_end_ps - session_start_ps, "duration mismatch")

endmodule

bind packet_burst_session_detector bsd_checker u_bsd_checker (.*);
